// ----- sv/qnorm_pkg.sv -----
// Shared types and constants for the quaternion normalizer.
`timescale 1ns / 1ps
package qnorm_pkg;

	// Number of quaternion components.
	localparam int NCOMP = 4;
	// Unit length in Q1.14.
	localparam logic [14:0] UNIT_ONE = 15'd16384;
	// Width of the radicand s * 256 and of the square-root datapath.
	localparam int RAD_W = 42;
	// Width of the root r.
	localparam int ROOT_W = 21;
	// Number of quotient bits produced by the divider.
	localparam int QUO_W = 15;
	// Width of the divider remainder.
	localparam int REM_W = ROOT_W + QUO_W - 1;

	// Per-item sideband that travels beside the root computation.
	typedef struct packed {
		logic [NCOMP-1:0][15:0] mag;
		logic [NCOMP-1:0]       neg;
		logic                   zero;
	} side_t;

endpackage

// ----- sv/qnorm_sumsq.sv -----
// Two-stage sum of squares with magnitude and sign extraction.
`timescale 1ns / 1ps
`default_nettype none
module qnorm_sumsq (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic [qnorm_pkg::NCOMP-1:0][15:0]    comp,
	output logic                                      out_valid,
	output logic [qnorm_pkg::RAD_W-1:0]               radicand,
	output qnorm_pkg::side_t                          side
);
	import qnorm_pkg::*;

	logic                       valid_s1;
	logic [NCOMP-1:0][30:0]     sq_s1;
	side_t                      side_s1;
	logic                       valid_s2;
	logic [RAD_W-1:0]           rad_s2;
	side_t                      side_s2;
	logic [NCOMP-1:0][15:0]     mag;
	logic [32:0]                sum;

	// Magnitudes of the signed inputs; -32768 maps to 32768.
	always_comb begin
		for (int i = 0; i < NCOMP; i++) begin
			mag[i] = comp[i][15] ? (16'd0 - comp[i]) : comp[i];
		end
	end

	// Stage 1 squares each magnitude.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NCOMP; i++) begin
			sq_s1[i]       <= {15'd0, mag[i]} * {15'd0, mag[i]};
			side_s1.mag[i] <= mag[i];
			side_s1.neg[i] <= comp[i][15];
		end
		side_s1.zero <= (comp == '0);
	end

	// Stage 2 adds the squares and scales the sum by 256.
	assign sum = 33'(sq_s1[0]) + 33'(sq_s1[1]) + 33'(sq_s1[2]) + 33'(sq_s1[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		rad_s2  <= {1'b0, sum, 8'd0};
		side_s2 <= side_s1;
	end

	assign out_valid = valid_s2;
	assign radicand  = rad_s2;
	assign side      = side_s2;
endmodule
`default_nettype wire

// ----- sv/qnorm_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module qnorm_sqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [qnorm_pkg::RAD_W-1:0] radicand,
	input  wire qnorm_pkg::side_t           in_side,
	output logic                            out_valid,
	output logic [qnorm_pkg::ROOT_W-1:0]    root,
	output qnorm_pkg::side_t                out_side
);
	import qnorm_pkg::*;

	localparam int NSTG = ROOT_W;

	logic [NSTG:0]             vld;
	logic [NSTG:0][RAD_W-1:0]  rem;
	logic [NSTG:0][RAD_W-1:0]  res;
	side_t                     sd [NSTG+1];

	assign vld[0] = in_valid;
	assign rem[0] = radicand;
	assign res[0] = '0;
	assign sd[0]  = in_side;

	// Each stage tests one power of four against the remaining radicand.
	for (genvar i = 0; i < NSTG; i++) begin : g_stg
		localparam logic [RAD_W-1:0] BITV = RAD_W'(1) << (2 * (NSTG - 1 - i));
		logic [RAD_W-1:0] trial;
		logic             take;

		assign trial = res[i] + BITV;
		assign take  = (rem[i] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else begin
				vld[i+1] <= vld[i];
			end
		end

		always_ff @(posedge clk) begin
			if (take) begin
				rem[i+1] <= rem[i] - trial;
				res[i+1] <= (res[i] >> 1) + BITV;
			end else begin
				rem[i+1] <= rem[i];
				res[i+1] <= res[i] >> 1;
			end
			sd[i+1] <= sd[i];
		end
	end

	assign out_valid = vld[NSTG];
	assign root      = res[NSTG][ROOT_W-1:0];
	assign out_side  = sd[NSTG];
endmodule
`default_nettype wire

// ----- sv/qnorm_div.sv -----
// Pipelined restoring divider, four lanes sharing one divisor.
`timescale 1ns / 1ps
`default_nettype none
module qnorm_div (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	input  wire logic [qnorm_pkg::ROOT_W-1:0]            root,
	input  wire qnorm_pkg::side_t                        in_side,
	output logic                                         out_valid,
	output logic [qnorm_pkg::NCOMP-1:0][qnorm_pkg::QUO_W-1:0] quo,
	output qnorm_pkg::side_t                             out_side
);
	import qnorm_pkg::*;

	localparam int NSTG = QUO_W;

	logic [NSTG:0]                        vld;
	logic [NSTG:0][ROOT_W-1:0]            dvs;
	logic [NSTG:0][NCOMP-1:0][REM_W-1:0]  rem;
	logic [NSTG:0][NCOMP-1:0][QUO_W-1:0]  q;
	side_t                                sd [NSTG+1];

	// Dividend is the magnitude scaled by 2^18.
	assign vld[0] = in_valid;
	assign dvs[0] = root;
	assign sd[0]  = in_side;
	for (genvar l = 0; l < NCOMP; l++) begin : g_init
		assign rem[0][l] = {1'b0, in_side.mag[l], 18'd0};
		assign q[0][l]   = '0;
	end

	// Each stage decides one quotient bit, most significant first.
	for (genvar i = 0; i < NSTG; i++) begin : g_stg
		localparam int SH = NSTG - 1 - i;
		logic [REM_W-1:0] shifted;

		assign shifted = REM_W'(dvs[i]) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else begin
				vld[i+1] <= vld[i];
			end
		end

		always_ff @(posedge clk) begin
			dvs[i+1] <= dvs[i];
			sd[i+1]  <= sd[i];
			for (int l = 0; l < NCOMP; l++) begin
				if (rem[i][l] >= shifted) begin
					rem[i+1][l] <= rem[i][l] - shifted;
					q[i+1][l]   <= q[i][l] | (QUO_W'(1) << SH);
				end else begin
					rem[i+1][l] <= rem[i][l];
					q[i+1][l]   <= q[i][l];
				end
			end
		end
	end

	assign out_valid = vld[NSTG];
	assign quo       = q[NSTG];
	assign out_side  = sd[NSTG];
endmodule
`default_nettype wire

// ----- sv/quaternion_normalizer_unit.sv -----
// Top level of the quaternion normalizer.
//
// Usage: drive comp_x..comp_w (signed Q4.12) and pulse start; a transaction
// is accepted on any rising edge with start high and busy low. busy is always
// low, so a new quaternion can be taken every cycle.
// Each result appears on unit_x..unit_w (signed Q1.14, saturated to
// +/-16384) and was_zero for exactly one cycle, marked by done.
// A result passes through the sum of squares, the square root (one root bit
// per stage), the divider (one quotient bit per stage) and then saturation
// and the output register. Throughput is one quaternion per cycle.
// A zero quaternion returns (0, 0, 0, 16384) with was_zero set.
// Reset clears all valid bits, so no done pulse follows reset until a new
// transaction arrives. The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_normalizer_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] comp_x,
	input  wire logic signed [15:0] comp_y,
	input  wire logic signed [15:0] comp_z,
	input  wire logic signed [15:0] comp_w,
	output logic                    done,
	output logic signed [15:0]      unit_x,
	output logic signed [15:0]      unit_y,
	output logic signed [15:0]      unit_z,
	output logic signed [15:0]      unit_w,
	output logic                    was_zero
);
	import qnorm_pkg::*;

	logic                          ss_valid;
	logic [RAD_W-1:0]              ss_rad;
	side_t                         ss_side;
	logic                          sq_valid;
	logic [ROOT_W-1:0]             sq_root;
	side_t                         sq_side;
	logic                          dv_valid;
	logic [NCOMP-1:0][QUO_W-1:0]   dv_quo;
	side_t                         dv_side;
	logic [NCOMP-1:0][15:0]        comp;
	logic [NCOMP-1:0][15:0]        fin;
	logic                          done_q;
	logic [NCOMP-1:0][15:0]        unit_q;
	logic                          zero_q;

	assign busy = 1'b0;
	assign comp = {comp_w, comp_z, comp_y, comp_x};

	qnorm_sumsq u_sumsq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.comp      (comp),
		.out_valid (ss_valid),
		.radicand  (ss_rad),
		.side      (ss_side)
	);

	qnorm_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ss_valid),
		.radicand  (ss_rad),
		.in_side   (ss_side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	qnorm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.root      (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.out_side  (dv_side)
	);

	// Saturate, restore the sign and apply the zero-quaternion rule.
	always_comb begin
		logic [14:0] sat;
		for (int i = 0; i < NCOMP; i++) begin
			sat = (dv_quo[i] > UNIT_ONE) ? UNIT_ONE : dv_quo[i];
			fin[i] = dv_side.neg[i] ? (16'd0 - {1'b0, sat}) : {1'b0, sat};
		end
		if (dv_side.zero) begin
			fin = '0;
			fin[NCOMP-1] = {1'b0, UNIT_ONE};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		unit_q <= fin;
		zero_q <= dv_side.zero;
	end

	assign done     = done_q;
	assign unit_x   = unit_q[0];
	assign unit_y   = unit_q[1];
	assign unit_z   = unit_q[2];
	assign unit_w   = unit_q[3];
	assign was_zero = zero_q;
endmodule
`default_nettype wire

// ----- test/tb_quaternion_normalizer_unit.sv -----
// Self-checking testbench for the quaternion normalizer unit.
`timescale 1ns / 1ps
`default_nettype none

// Keeps the expected unit quaternions and compares them with the block's results.
class unit_quat_board;
	logic [15:0] exp_x[$], exp_y[$], exp_z[$], exp_w[$];
	logic        exp_zero[$];
	int          errors = 0;

	// Integer square root of a 42-bit radicand, one bit pair at a time.
	function automatic longint unsigned root_of(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Scales one component by 2^18 / r, truncating and saturating.
	function automatic logic [15:0] scale_comp(logic signed [15:0] c, longint unsigned r);
		longint unsigned mag, q;
		longint          v;
		mag = (c < 0) ? longint'(-longint'(c)) : longint'(c);
		q = (mag << 18) / r;
		if (q > 16384) q = 16384;
		v = (c < 0) ? -longint'(q) : longint'(q);
		return v[15:0];
	endfunction

	// Notes an accepted transaction and stores its expected result.
	function void note_input(logic signed [15:0] x, y, z, w);
		longint unsigned s, r;
		logic signed [15:0] c[4];
		c[0] = x; c[1] = y; c[2] = z; c[3] = w;
		s = 0;
		foreach (c[i]) s += longint'(c[i]) * longint'(c[i]);
		if (s == 0) begin
			exp_x.push_back(16'd0); exp_y.push_back(16'd0); exp_z.push_back(16'd0);
			exp_w.push_back(16'd16384); exp_zero.push_back(1'b1);
		end else begin
			r = root_of(s << 8);
			exp_x.push_back(scale_comp(x, r)); exp_y.push_back(scale_comp(y, r));
			exp_z.push_back(scale_comp(z, r)); exp_w.push_back(scale_comp(w, r));
			exp_zero.push_back(1'b0);
		end
	endfunction

	// Compares one result with the oldest expectation.
	function void check_result(logic [15:0] x, y, z, w, logic zf);
		logic [15:0] ex, ey, ez, ew;
		logic        ezf;
		if (exp_x.size() == 0) begin
			$error("result arrived with no transaction outstanding");
			errors++;
			return;
		end
		ex = exp_x.pop_front(); ey = exp_y.pop_front(); ez = exp_z.pop_front();
		ew = exp_w.pop_front(); ezf = exp_zero.pop_front();
		if (x !== ex) begin $error("unit_x exp %0d got %0d", $signed(ex), $signed(x)); errors++; end
		if (y !== ey) begin $error("unit_y exp %0d got %0d", $signed(ey), $signed(y)); errors++; end
		if (z !== ez) begin $error("unit_z exp %0d got %0d", $signed(ez), $signed(z)); errors++; end
		if (w !== ew) begin $error("unit_w exp %0d got %0d", $signed(ew), $signed(w)); errors++; end
		if (zf !== ezf) begin $error("was_zero exp %0d got %0d", ezf, zf); errors++; end
	endfunction

	function int pending();
		return exp_x.size();
	endfunction
endclass

module tb_quaternion_normalizer_unit;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, was_zero;
	logic signed [15:0] comp_x = '0, comp_y = '0, comp_z = '0, comp_w = '0;
	logic signed [15:0] unit_x, unit_y, unit_z, unit_w;

	unit_quat_board board = new();
	int idle_pct = 0;
	int stall_cycles = 0;
	bit timed_out = 0;

	quaternion_normalizer_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z), .comp_w(comp_w),
		.done(done), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.unit_w(unit_w), .was_zero(was_zero)
	);

	always #6 clk = ~clk;

	// Accepted transactions and results are both sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) board.note_input(comp_x, comp_y, comp_z, comp_w);
			if (done) board.check_result(unit_x, unit_y, unit_z, unit_w, was_zero);
			if ((start && !busy) || done) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
		end
	end

	// Watchdog on cycles without any accepted transaction or result.
	always @(posedge clk) begin
		if (stall_cycles >= WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("quaternion_normalizer_unit verification failed");
			$finish;
		end
	end

	// Drives one quaternion, with random idle cycles ahead of it.
	task automatic send_quat(logic signed [15:0] x, y, z, w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		comp_x <= x; comp_y <= y; comp_z <= z; comp_w <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Picks a component: mostly full range, sometimes extremes or small values.
	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'($signed($urandom_range(8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	// Waits for every outstanding result.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	initial begin
		logic signed [15:0] d[4];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, extremes, single-axis, tiny and overshoot-prone values.
		send_quat(0, 0, 0, 0);
		send_quat(-32768, -32768, -32768, -32768);
		send_quat(32767, 32767, 32767, 32767);
		send_quat(-32768, 0, 0, 0);
		send_quat(0, 32767, 0, 0);
		send_quat(0, 0, -32768, 0);
		send_quat(0, 0, 0, 4096);
		send_quat(0, 0, 0, -1);
		send_quat(1, 0, 0, 0);
		send_quat(1, 1, 1, 1);
		send_quat(-1, -1, -1, -1);
		send_quat(0, 0, 0, 0);
		send_quat(3, -4, 0, 0);
		send_quat(32767, -32768, 1, -1);
		send_quat(1, 0, 0, 32767);
		send_quat(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
		// The sender holds off until the pipeline is empty.
		drain();

		// Random phases: sender idles 6 percent, then 56 percent, then never.
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 6 : (phase == 1) ? 56 : 0;
			for (int n = 0; n < 366; n++) begin
				foreach (d[i]) d[i] = rand_comp();
				send_quat(d[0], d[1], d[2], d[3]);
			end
			drain();
		end

		repeat (45) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("quaternion_normalizer_unit verification clean");
		else
			$display("quaternion_normalizer_unit verification failed");
		$finish;
	end
endmodule

// ----- sim.f -----
sv/qnorm_pkg.sv
sv/qnorm_sumsq.sv
sv/qnorm_sqrt.sv
sv/qnorm_div.sv
sv/quaternion_normalizer_unit.sv
test/tb_quaternion_normalizer_unit.sv
